FILE: hw/rtl/arws_pkg.sv
`default_nettype none

package arws_pkg;

  localparam int unsigned COORD_W = 7;
  localparam int unsigned THR_W   = 32;
  localparam int unsigned DRAW_W  = 31;
  localparam int unsigned LCG_W   = 64;
  localparam int unsigned HIT_W   = 8;
  localparam int unsigned IDX_W   = 4;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [THR_W-1:0]   thr_t;
  typedef logic [DRAW_W-1:0]  draw_t;
  typedef logic [LCG_W-1:0]   lcg_t;

  localparam coord_t GRID_MAX = 7'd127;

  localparam logic [31:0] LCG_MUL = 32'd1103515245;
  localparam logic [31:0] LCG_ADD = 32'd12345;
  // generator state 1 already advanced once
  localparam lcg_t LCG_NEXT_RST = 64'd1103527590;

  localparam coord_t GRID_LIMIT_RST = 7'd20;

  typedef enum logic [IDX_W-1:0] {
    REG_THR_RIGHT      = 4'd0,
    REG_THR_LEFT       = 4'd1,
    REG_THR_DOWN       = 4'd2,
    REG_THR_BOTH_DOWN  = 4'd3,
    REG_THR_RIGHT_DOWN = 4'd4,
    REG_GRID_LIMIT     = 4'd5,
    REG_START_X        = 4'd6,
    REG_START_Y        = 4'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    BND_NONE  = 2'd0,
    BND_XLINE = 2'd1,
    BND_YLINE = 2'd2,
    BND_DIAG  = 2'd3
  } bound_e;

  typedef struct packed {
    thr_t   thr_right;
    thr_t   thr_left;
    thr_t   thr_down;
    thr_t   thr_both_down;
    thr_t   thr_right_down;
    coord_t grid_limit;
    coord_t start_x;
    coord_t start_y;
  } regs_t;

  typedef struct packed {
    logic             absorbed;
    bound_e           boundary;
    logic [HIT_W-1:0] hit_index;
    coord_t           walker_x;
    coord_t           walker_y;
  } res_t;

  function automatic coord_t clamp_coord(input coord_t v);
    return (v > GRID_MAX) ? GRID_MAX : v;
  endfunction

  function automatic coord_t inc_coord(input coord_t v);
    return (v >= GRID_MAX) ? GRID_MAX : v + coord_t'(1);
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/arws_if.sv
`default_nettype none

interface arws_in_if import arws_pkg::*;;
  logic valid;
  logic ready;
  logic kind;
  lcg_t seed_value;

  modport source (output valid, kind, seed_value, input ready);
  modport sink   (input valid, kind, seed_value, output ready);
endinterface

interface arws_out_if import arws_pkg::*;;
  logic             valid;
  logic             ready;
  logic             absorbed;
  logic [1:0]       boundary;
  logic [HIT_W-1:0] hit_index;
  coord_t           walker_x;
  coord_t           walker_y;

  modport source (output valid, absorbed, boundary, hit_index, walker_x, walker_y,
                  input ready);
  modport sink   (input valid, absorbed, boundary, hit_index, walker_x, walker_y,
                  output ready);
endinterface

interface arws_cfg_if import arws_pkg::*;;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] index;
  thr_t             data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/arws_regs.sv
`default_nettype none

module arws_regs import arws_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_en_i,
  input  wire logic [IDX_W-1:0] wr_idx_i,
  input  wire thr_t             wr_data_i,
  output regs_t                 regs_o
);

  regs_t regs_q, regs_d;

  always_comb begin
    regs_d = regs_q;
    if (wr_en_i) begin
      unique case (wr_idx_i)
        REG_THR_RIGHT:      regs_d.thr_right      = wr_data_i;
        REG_THR_LEFT:       regs_d.thr_left       = wr_data_i;
        REG_THR_DOWN:       regs_d.thr_down       = wr_data_i;
        REG_THR_BOTH_DOWN:  regs_d.thr_both_down  = wr_data_i;
        REG_THR_RIGHT_DOWN: regs_d.thr_right_down = wr_data_i;
        REG_GRID_LIMIT:     regs_d.grid_limit     = wr_data_i[COORD_W-1:0];
        REG_START_X:        regs_d.start_x        = wr_data_i[COORD_W-1:0];
        REG_START_Y:        regs_d.start_y        = wr_data_i[COORD_W-1:0];
        default:            regs_d = regs_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs_q <= '{thr_right:      '0,
                  thr_left:       '0,
                  thr_down:       '0,
                  thr_both_down:  '0,
                  thr_right_down: '0,
                  grid_limit:     GRID_LIMIT_RST,
                  start_x:        '0,
                  start_y:        '0};
    end else begin
      regs_q <= regs_d;
    end
  end

  assign regs_o = regs_q;

endmodule

`default_nettype wire

FILE: hw/rtl/arws_lcg.sv
`default_nettype none

module arws_lcg import arws_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic step_i,
  input  wire logic seed_load_i,
  input  wire lcg_t seed_i,
  output draw_t     draw_o
);

  // next_q holds the state the next step lands on, so the draw leaves a register
  lcg_t        next_q, next_d;
  lcg_t        mul_src;
  lcg_t        prod_lo;
  logic [31:0] prod_hi;

  always_comb begin
    mul_src = seed_load_i ? seed_i : next_q;
    prod_lo = LCG_W'(mul_src[31:0]) * LCG_W'(LCG_MUL);
    prod_hi = mul_src[LCG_W-1:32] * LCG_MUL;
    next_d  = prod_lo + {prod_hi, 32'h0} + LCG_W'(LCG_ADD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_q <= LCG_NEXT_RST;
    end else if (step_i || seed_load_i) begin
      next_q <= next_d;
    end
  end

  assign draw_o = next_q[62:32];

endmodule

`default_nettype wire

FILE: hw/rtl/arws_walk.sv
`default_nettype none

module arws_walk import arws_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  step_i,
  input  wire logic  seed_load_i,
  input  wire draw_t draw_i,
  input  wire regs_t regs_i,
  output res_t       res_o
);

  coord_t pos_x_q, pos_x_d;
  coord_t pos_y_q, pos_y_d;
  logic   fresh_q, fresh_d;

  coord_t           start_x, start_y;
  coord_t           base_x, base_y;
  coord_t           x_inc, x_dec, y_dec;
  logic             x_zero, y_zero;
  logic             diag_hit;
  logic [THR_W-1:0] draw_ext;
  coord_t           nx, ny;
  bound_e           bnd;
  logic [HIT_W-1:0] hit;
  logic             absorbed;

  always_comb begin
    start_x  = clamp_coord(regs_i.start_x);
    start_y  = clamp_coord(regs_i.start_y);
    base_x   = fresh_q ? start_x : pos_x_q;
    base_y   = fresh_q ? start_y : pos_y_q;
    x_inc    = inc_coord(base_x);
    x_dec    = base_x - coord_t'(1);
    y_dec    = base_y - coord_t'(1);
    x_zero   = (base_x == '0);
    y_zero   = (base_y == '0);
    diag_hit = ({1'b0, x_inc} + {1'b0, base_y}) > {1'b0, regs_i.grid_limit};
    draw_ext = {1'b0, draw_i};

    nx  = base_x;
    ny  = base_y;
    bnd = BND_NONE;
    hit = '0;
    if (draw_ext < regs_i.thr_right) begin
      nx = x_inc;
      if (diag_hit) begin
        bnd = BND_DIAG;
        hit = HIT_W'(base_y);
      end
    end else if (draw_ext < regs_i.thr_left) begin
      nx = x_dec;
      if (x_zero) begin
        bnd = BND_XLINE;
        hit = HIT_W'(base_y) + HIT_W'(1);
      end
    end else if (draw_ext < regs_i.thr_down) begin
      ny = y_dec;
      if (y_zero) begin
        bnd = BND_YLINE;
        hit = HIT_W'(base_x);
      end
    end else if (draw_ext < regs_i.thr_both_down) begin
      nx = x_dec;
      ny = y_dec;
      if (x_zero && y_zero) begin
        bnd = BND_XLINE;
        hit = '0;
      end else if (x_zero) begin
        bnd = BND_XLINE;
        hit = HIT_W'(base_y);
      end else if (y_zero) begin
        bnd = BND_YLINE;
        hit = HIT_W'(x_dec);
      end
    end else if (draw_ext < regs_i.thr_right_down) begin
      nx = x_inc;
      ny = y_dec;
      if (y_zero) begin
        bnd = BND_YLINE;
        hit = HIT_W'(x_inc);
      end
    end
    absorbed = (bnd != BND_NONE);

    pos_x_d = pos_x_q;
    pos_y_d = pos_y_q;
    fresh_d = fresh_q;
    if (step_i) begin
      fresh_d = absorbed;
      if (!absorbed) begin
        pos_x_d = nx;
        pos_y_d = ny;
      end
    end

    if (seed_load_i) begin
      res_o.absorbed  = 1'b0;
      res_o.boundary  = BND_NONE;
      res_o.hit_index = '0;
      res_o.walker_x  = base_x;
      res_o.walker_y  = base_y;
    end else begin
      res_o.absorbed  = absorbed;
      res_o.boundary  = bnd;
      res_o.hit_index = hit;
      res_o.walker_x  = absorbed ? start_x : nx;
      res_o.walker_y  = absorbed ? start_y : ny;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_x_q <= '0;
      pos_y_q <= '0;
      fresh_q <= 1'b1;
    end else begin
      pos_x_q <= pos_x_d;
      pos_y_q <= pos_y_d;
      fresh_q <= fresh_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/arws_obuf.sv
`default_nettype none

module arws_obuf import arws_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t data_i,
  output logic      ready_o,
  output logic      valid_o,
  output res_t      data_o,
  input  wire logic ready_i
);

  res_t out_q;
  res_t skid_q;
  logic out_vld_q;
  logic skid_vld_q;
  logic pop;

  assign pop     = out_vld_q && ready_i;
  assign ready_o = !skid_vld_q;
  assign valid_o = out_vld_q;
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (pop) begin
        skid_vld_q <= 1'b0;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_vld_q <= 1'b1;
      end else begin
        skid_vld_q <= 1'b1;
      end
    end else if (pop) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push_i) begin
      if (!out_vld_q || pop) begin
        out_q <= data_i;
      end else begin
        skid_q <= data_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/absorbing_random_walk_stepper.sv
// Random walk stepper on a triangular grid with absorbing boundaries.
// Channels: in_i (valid/ready) carries kind and seed_value; kind 0 takes one
// walk step, kind 1 loads the 64-bit generator state. out_o (valid/ready)
// returns one result beat per input beat: absorbed, boundary, hit_index and
// the walker position. cfg_i (valid/ready, index/data) writes the thresholds,
// grid_limit and the start point; it is always ready and should be written
// only while no step is in flight.
// Results are registered in the output buffer; while it has room, in_i takes
// one beat per cycle. The generator advance (two 32-bit constant
// multiplies and an add) and the move decode each fit between registers.
// Reset: generator state 1, walker restarts from the start point on the next
// step, thresholds 0, grid_limit 20. The output has a two-beat buffer: a
// stalled receiver holds the current result, one more beat is absorbed, then
// in_i.ready drops until out_o.ready returns.
`default_nettype none

module absorbing_random_walk_stepper import arws_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  arws_in_if.sink   in_i,
  arws_out_if.source out_o,
  arws_cfg_if.sink  cfg_i
);

  regs_t regs;
  draw_t draw;
  res_t  res;
  res_t  out_res;
  logic  in_ready;
  logic  accept;
  logic  step;
  logic  seed_load;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = in_ready;
  assign accept      = in_i.valid && in_ready;
  assign step        = accept && !in_i.kind;
  assign seed_load   = accept && in_i.kind;

  arws_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_i.valid),
    .wr_idx_i  (cfg_i.index),
    .wr_data_i (cfg_i.data),
    .regs_o    (regs)
  );

  arws_lcg u_lcg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .seed_load_i (seed_load),
    .seed_i      (in_i.seed_value),
    .draw_o      (draw)
  );

  arws_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .seed_load_i (seed_load),
    .draw_i      (draw),
    .regs_i      (regs),
    .res_o       (res)
  );

  arws_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (in_ready),
    .valid_o (out_o.valid),
    .data_o  (out_res),
    .ready_i (out_o.ready)
  );

  assign out_o.absorbed  = out_res.absorbed;
  assign out_o.boundary  = out_res.boundary;
  assign out_o.hit_index = out_res.hit_index;
  assign out_o.walker_x  = out_res.walker_x;
  assign out_o.walker_y  = out_res.walker_y;

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import arws_pkg::*;

  localparam int   CYCLE_LIMIT = 500000;
  localparam thr_t THR_ONE     = 32'h8000_0000;
  localparam logic KIND_STEP   = 1'b0;
  localparam logic KIND_SEED   = 1'b1;

  logic clk_i = 1'b0;
  logic rst_ni;

  arws_in_if  in_if();
  arws_out_if out_if();
  arws_cfg_if cfg_if();

  absorbing_random_walk_stepper dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // walker predictor state
  lcg_t walk_lcg;
  int   walk_x;
  int   walk_y;
  bit   walk_fresh;
  thr_t thr_tab[5];
  int   diag_limit;
  int   start_x;
  int   start_y;

  res_t walk_expect_q[$];
  res_t want;

  bit idle_en;
  int err_cnt;
  int cycle_cnt;
  int stall_left;
  int n_steps;
  int n_seeds;
  int n_cfg;
  int beats_checked;
  int n_xline;
  int n_yline;
  int n_diag;

  task automatic report_mismatch(input string msg);
    $display("[%0t] beat %0d: %s", $time, beats_checked, msg);
    err_cnt++;
  endtask

  function automatic res_t advance_walker(input logic is_seed, input lcg_t seed_v);
    res_t  r;
    int    nx;
    int    ny;
    draw_t d;
    r = '0;
    if (is_seed) begin
      walk_lcg = seed_v;
      nx = walk_fresh ? start_x : walk_x;
      ny = walk_fresh ? start_y : walk_y;
    end else begin
      if (walk_fresh) begin
        walk_x = start_x;
        walk_y = start_y;
        walk_fresh = 1'b0;
      end
      nx = walk_x;
      ny = walk_y;
      walk_lcg = walk_lcg * lcg_t'(LCG_MUL) + lcg_t'(LCG_ADD);
      d = walk_lcg[62:32];
      if ({1'b0, d} < thr_tab[0]) begin
        nx = (nx >= int'(GRID_MAX)) ? int'(GRID_MAX) : nx + 1;
        if (nx + ny > diag_limit) begin
          r.boundary = BND_DIAG;
          r.hit_index = 8'(ny);
        end
      end else if ({1'b0, d} < thr_tab[1]) begin
        nx = nx - 1;
        if (nx < 0) begin
          r.boundary = BND_XLINE;
          r.hit_index = 8'(ny + 1);
        end
      end else if ({1'b0, d} < thr_tab[2]) begin
        ny = ny - 1;
        if (ny < 0) begin
          r.boundary = BND_YLINE;
          r.hit_index = 8'(nx);
        end
      end else if ({1'b0, d} < thr_tab[3]) begin
        nx = nx - 1;
        ny = ny - 1;
        if (nx < 0 && ny < 0) begin
          r.boundary = BND_XLINE;
          r.hit_index = '0;
        end else if (nx < 0) begin
          r.boundary = BND_XLINE;
          r.hit_index = 8'(ny + 1);
        end else if (ny < 0) begin
          r.boundary = BND_YLINE;
          r.hit_index = 8'(nx);
        end
      end else if ({1'b0, d} < thr_tab[4]) begin
        nx = (nx >= int'(GRID_MAX)) ? int'(GRID_MAX) : nx + 1;
        ny = ny - 1;
        if (ny < 0) begin
          r.boundary = BND_YLINE;
          r.hit_index = 8'(nx);
        end
      end
      if (r.boundary != BND_NONE) begin
        r.absorbed = 1'b1;
        walk_fresh = 1'b1;
        nx = start_x;
        ny = start_y;
      end else begin
        walk_x = nx;
        walk_y = ny;
      end
    end
    r.walker_x = coord_t'(nx);
    r.walker_y = coord_t'(ny);
    return r;
  endfunction

  function automatic int pick_gap(input bit may_skip);
    int r;
    r = $urandom_range(0, 99);
    if (!idle_en || (may_skip && r < 50)) return 0;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 9);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_step(input logic is_seed, input lcg_t seed_v, input int gap);
    @(negedge clk_i);
    in_if.valid <= 1'b1;
    in_if.kind <= is_seed;
    in_if.seed_value <= seed_v;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    walk_expect_q.push_back(advance_walker(is_seed, seed_v));
    if (is_seed == KIND_SEED) n_seeds++;
    else n_steps++;
    if (gap > 0) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic wait_results_drained;
    if (in_if.valid === 1'b1) begin
      @(negedge clk_i);
      in_if.valid <= 1'b0;
    end
    while (walk_expect_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input thr_t v);
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= v;
    @(posedge clk_i);
    while (cfg_if.ready !== 1'b1) @(posedge clk_i);
    case (idx)
      REG_GRID_LIMIT: diag_limit = int'(v[6:0]);
      REG_START_X:    start_x = int'(v[6:0]);
      REG_START_Y:    start_y = int'(v[6:0]);
      default:        thr_tab[int'(idx)] = v;
    endcase
    n_cfg++;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic program_walk(input thr_t r, input thr_t l, input thr_t d, input thr_t b,
                              input thr_t rd, input int lim, input int sx, input int sy);
    wait_results_drained;
    write_reg(REG_THR_RIGHT, r);
    write_reg(REG_THR_LEFT, l);
    write_reg(REG_THR_DOWN, d);
    write_reg(REG_THR_BOTH_DOWN, b);
    write_reg(REG_THR_RIGHT_DOWN, rd);
    write_reg(REG_GRID_LIMIT, thr_t'(lim));
    write_reg(REG_START_X, thr_t'(sx));
    write_reg(REG_START_Y, thr_t'(sy));
  endtask

  task automatic program_random_walk(input bit ordered, input bit far_start);
    int unsigned acc;
    thr_t        t[5];
    int          lim;
    int          sx;
    int          sy;
    int          r;
    acc = 0;
    for (int i = 0; i < 5; i++) begin
      if (ordered) begin
        acc = acc + $urandom_range(0, (32'h8000_0000 - acc) / 2);
        t[i] = acc;
      end else begin
        t[i] = $urandom_range(0, 32'h8000_0000);
      end
    end
    if (ordered && $urandom_range(0, 1)) t[4] = THR_ONE;
    r = $urandom_range(0, 9);
    lim = (r == 0) ? 1 : (r == 1) ? 127 : $urandom_range(2, 24);
    if (far_start) begin
      sx = $urandom_range(0, 127);
      sy = $urandom_range(0, 127);
    end else begin
      sx = $urandom_range(0, lim);
      sy = $urandom_range(0, lim - sx);
    end
    program_walk(t[0], t[1], t[2], t[3], t[4], lim, sx, sy);
  endtask

  task automatic run_walk_stream(input int n_items, input bit hold_mid);
    for (int i = 0; i < n_items; i++) begin
      if (hold_mid && i == n_items / 2) wait_results_drained;
      push_step(($urandom_range(0, 99) < 4) ? KIND_SEED : KIND_STEP,
                {$urandom, $urandom}, pick_gap(1'b1));
    end
  endtask

  // draws straight from the reset generator state
  task automatic test_generator_from_reset;
    program_walk(32'h2000_0000, 32'h4000_0000, 32'h6000_0000, 32'h7000_0000, THR_ONE,
                 3, 1, 1);
    repeat (4) push_step(KIND_STEP, '0, 0);
  endtask

  task automatic test_seed_and_idle;
    program_walk('0, '0, '0, '0, '0, 20, 0, 0);
    push_step(KIND_SEED, '0, 0);
    push_step(KIND_STEP, '0, 1);
    push_step(KIND_SEED, '1, 2);
    push_step(KIND_STEP, '0, 0);
  endtask

  task automatic test_each_move;
    program_walk('0, THR_ONE, '0, '0, '0, 20, 0, 127);
    push_step(KIND_STEP, '0, 0);
    push_step(KIND_STEP, '0, 1);
    program_walk(THR_ONE, '0, '0, '0, '0, 1, 0, 0);
    push_step(KIND_STEP, '0, 0);
    push_step(KIND_STEP, '0, 0);
    // x saturates at the grid edge, then a seed load mid-walk
    program_walk(THR_ONE, '0, '0, '0, '0, 127, 127, 0);
    push_step(KIND_STEP, '0, 0);
    push_step(KIND_SEED, {$urandom, $urandom}, 0);
    program_walk('0, '0, '0, '0, THR_ONE, 127, 127, 0);
    push_step(KIND_STEP, '0, 0);
    program_walk(THR_ONE, '0, '0, '0, '0, 127, 127, 127);
    push_step(KIND_STEP, '0, 0);
    program_walk('0, '0, THR_ONE, '0, '0, 20, 3, 0);
    push_step(KIND_STEP, '0, 0);
    // both-down: corner, x line only, y line only
    program_walk('0, '0, '0, THR_ONE, '0, 20, 0, 0);
    push_step(KIND_STEP, '0, 0);
    program_walk('0, '0, '0, THR_ONE, '0, 20, 0, 4);
    push_step(KIND_STEP, '0, 0);
    program_walk('0, '0, '0, THR_ONE, '0, 20, 4, 0);
    push_step(KIND_STEP, '0, 0);
  endtask

  task automatic test_random_walks;
    for (int ph = 0; ph < 6; ph++) begin
      idle_en = (ph != 1);
      program_random_walk(ph != 4, ph == 5);
      run_walk_stream(215, ph == 2);
    end
    idle_en = 1'b1;
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
    end else if (idle_en && $urandom_range(0, 3) == 0) begin
      out_if.ready <= 1'b0;
      stall_left = pick_gap(1'b0) - 1;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (walk_expect_q.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        want = walk_expect_q.pop_front();
        if (out_if.absorbed !== want.absorbed)
          report_mismatch($sformatf("absorbed got %0h want %0h", out_if.absorbed,
                                    want.absorbed));
        if (out_if.boundary !== want.boundary)
          report_mismatch($sformatf("boundary got %0h want %0h", out_if.boundary,
                                    want.boundary));
        if (out_if.hit_index !== want.hit_index)
          report_mismatch($sformatf("hit_index got %0d want %0d", out_if.hit_index,
                                    want.hit_index));
        if (out_if.walker_x !== want.walker_x)
          report_mismatch($sformatf("walker_x got %0d want %0d", out_if.walker_x,
                                    want.walker_x));
        if (out_if.walker_y !== want.walker_y)
          report_mismatch($sformatf("walker_y got %0d want %0d", out_if.walker_y,
                                    want.walker_y));
        case (want.boundary)
          BND_XLINE: n_xline++;
          BND_YLINE: n_yline++;
          BND_DIAG:  n_diag++;
          default:   ;
        endcase
      end
      beats_checked++;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("absorbing_random_walk_stepper regression: fail");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_STEP;
    in_if.seed_value = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = REG_THR_RIGHT;
    cfg_if.data = '0;
    walk_lcg = 64'd1;
    walk_x = 0;
    walk_y = 0;
    walk_fresh = 1'b1;
    for (int i = 0; i < 5; i++) thr_tab[i] = '0;
    diag_limit = int'(GRID_LIMIT_RST);
    start_x = 0;
    start_y = 0;
    idle_en = 1'b1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_generator_from_reset;
    test_seed_and_idle;
    test_each_move;
    test_random_walks;

    wait_results_drained;
    repeat (3) @(posedge clk_i);
    $display("walk steps %0d, seed loads %0d, register writes %0d, beats checked %0d",
             n_steps, n_seeds, n_cfg, beats_checked);
    $display("absorbed on x line %0d, y line %0d, diagonal %0d; %0d mismatches",
             n_xline, n_yline, n_diag, err_cnt);
    if (err_cnt == 0) begin
      $display("absorbing_random_walk_stepper regression: pass");
    end else begin
      $display("absorbing_random_walk_stepper regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/arws_pkg.sv
hw/rtl/arws_if.sv
hw/rtl/arws_regs.sv
hw/rtl/arws_lcg.sv
hw/rtl/arws_walk.sv
hw/rtl/arws_obuf.sv
hw/rtl/absorbing_random_walk_stepper.sv
bench/tb_top.sv
